### rtl/core/oskv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oskv_pkg
// Shared types, codes and helpers for the linear-scan key-value store.
// ----------------------------------------------------------------------------
package oskv_pkg;

	localparam int CAPACITY  = 256;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int DATA_W    = 64;
	localparam int BYTES     = DATA_W / 8;
	localparam int SIZE_W    = 4;
	localparam int ENTRY_W   = 2 * DATA_W;
	localparam int CFG_IDX_W = 1;

	// actions
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_FETCH  = 2'd1;
	localparam logic [1:0] ACT_EVICT  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_LEN_ERR   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_BYTES = 1'd1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(BYTES);

	typedef struct packed {
		logic [1:0]        action;
		logic [DATA_W-1:0] key;
		logic [SIZE_W-1:0] key_length;
		logic [DATA_W-1:0] value_in;
		logic [SIZE_W-1:0] value_length;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] value_out;
	} rsp_t;

	// effective sizes from the configuration registers
	typedef struct packed {
		logic [SIZE_W-1:0] key_eff;
		logic [SIZE_W-1:0] value_eff;
	} size_cfg_t;

	// memory port request from the engine
	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   waddr;
		logic [ENTRY_W-1:0] wdata;
		logic               re;
		logic [IDX_W-1:0]   raddr;
	} mem_req_t;

	// sizes above the store width saturate at the store width
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
		return (r > SIZE_W'(BYTES)) ? SIZE_W'(BYTES) : r;
	endfunction

	// ones in the low n bytes
	function automatic logic [DATA_W-1:0] byte_mask(input logic [SIZE_W-1:0] n);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < BYTES; b++) begin
			if (SIZE_W'(b) < n) begin
				m[b*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

### rtl/core/oskv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oskv_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module oskv_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/core/oskv_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oskv_engine
// Request sequencer: insert, oblivious fetch scan, evict with compaction.
// ----------------------------------------------------------------------------
module oskv_engine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start_valid,
	output      logic                       start_ready,
	input  wire oskv_pkg::req_t             start_req,
	input  wire oskv_pkg::size_cfg_t        sizes,
	output      oskv_pkg::mem_req_t         mem_req,
	input  wire logic [oskv_pkg::ENTRY_W-1:0] mem_rdata,
	output      logic                       res_valid,
	input  wire logic                       res_ready,
	output      oskv_pkg::rsp_t             res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t                          state_q;
	logic [1:0]                      action_q;
	logic [oskv_pkg::DATA_W-1:0]     probe_q;
	logic [oskv_pkg::DATA_W-1:0]     val_q;
	logic [oskv_pkg::DATA_W-1:0]     kmask_q;
	logic                            kerr_q;
	logic                            verr_q;
	logic [oskv_pkg::CNT_W-1:0]      count_q;
	logic [oskv_pkg::CNT_W-1:0]      rd_idx_q;
	logic                            found_q;
	logic                            rvalid_s1;
	logic [oskv_pkg::IDX_W-1:0]      ridx_s1;
	logic [1:0]                      status_q;
	logic [oskv_pkg::DATA_W-1:0]     vout_q;

	logic                            issue;
	logic [oskv_pkg::DATA_W-1:0]     rd_key;
	logic [oskv_pkg::DATA_W-1:0]     rd_val;
	logic                            hit;
	logic                            ins_ok;

	assign issue  = (rd_idx_q < count_q);
	assign rd_key = mem_rdata[oskv_pkg::ENTRY_W-1 -: oskv_pkg::DATA_W];
	assign rd_val = mem_rdata[oskv_pkg::DATA_W-1:0];
	assign hit    = (((rd_key ^ probe_q) & kmask_q) == '0);
	assign ins_ok = !kerr_q && !verr_q
		&& (count_q < oskv_pkg::CNT_W'(oskv_pkg::CAPACITY));

	assign start_ready = (state_q == S_IDLE);
	assign res_valid   = (state_q == S_FINISH);
	assign res.status    = status_q;
	assign res.value_out = vout_q;

	always_comb begin
		mem_req       = '0;
		mem_req.re    = (state_q == S_SCAN) && issue;
		mem_req.raddr = rd_idx_q[oskv_pkg::IDX_W-1:0];
		if (state_q == S_DISPATCH && action_q == oskv_pkg::ACT_INSERT && ins_ok) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = count_q[oskv_pkg::IDX_W-1:0];
			mem_req.wdata = {probe_q, val_q};
		end else if (state_q == S_SCAN && action_q == oskv_pkg::ACT_EVICT
			&& rvalid_s1 && found_q) begin
			// shift down behind the removed entry
			mem_req.we    = 1'b1;
			mem_req.waddr = ridx_s1 - oskv_pkg::IDX_W'(1);
			mem_req.wdata = mem_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start_valid) begin
						action_q <= start_req.action;
						probe_q  <= start_req.key & oskv_pkg::byte_mask(start_req.key_length);
						val_q    <= start_req.value_in
							& oskv_pkg::byte_mask(start_req.value_length);
						kmask_q  <= oskv_pkg::byte_mask(sizes.key_eff);
						kerr_q   <= (start_req.key_length > sizes.key_eff);
						verr_q   <= (start_req.value_length > sizes.value_eff);
						state_q  <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					rd_idx_q  <= '0;
					found_q   <= 1'b0;
					rvalid_s1 <= 1'b0;
					unique case (action_q)
						oskv_pkg::ACT_INSERT: begin
							vout_q  <= '0;
							state_q <= S_FINISH;
							if (kerr_q || verr_q) begin
								status_q <= oskv_pkg::ST_LEN_ERR;
							end else if (!ins_ok) begin
								status_q <= oskv_pkg::ST_FULL;
							end else begin
								status_q <= oskv_pkg::ST_OK;
								count_q  <= count_q + oskv_pkg::CNT_W'(1);
							end
						end
						oskv_pkg::ACT_FETCH: begin
							if (kerr_q || verr_q) begin
								status_q <= oskv_pkg::ST_LEN_ERR;
								vout_q   <= '0;
								state_q  <= S_FINISH;
							end else begin
								status_q <= oskv_pkg::ST_OK;
								vout_q   <= val_q;
								state_q  <= S_SCAN;
							end
						end
						oskv_pkg::ACT_EVICT: begin
							vout_q <= '0;
							if (kerr_q) begin
								status_q <= oskv_pkg::ST_LEN_ERR;
								state_q  <= S_FINISH;
							end else begin
								status_q <= oskv_pkg::ST_OK;
								state_q  <= S_SCAN;
							end
						end
						default: begin
							status_q <= oskv_pkg::ST_OK;
							vout_q   <= '0;
							state_q  <= S_FINISH;
						end
					endcase
				end
				S_SCAN: begin
					rvalid_s1 <= issue;
					ridx_s1   <= rd_idx_q[oskv_pkg::IDX_W-1:0];
					if (issue) begin
						rd_idx_q <= rd_idx_q + oskv_pkg::CNT_W'(1);
					end
					if (rvalid_s1 && hit) begin
						if (action_q == oskv_pkg::ACT_FETCH) begin
							vout_q <= rd_val;
						end else begin
							found_q <= 1'b1;
						end
					end
					if (!issue && !rvalid_s1) begin
						state_q <= S_FINISH;
						if (action_q == oskv_pkg::ACT_EVICT) begin
							if (found_q) begin
								count_q <= count_q - oskv_pkg::CNT_W'(1);
							end else begin
								status_q <= oskv_pkg::ST_NOT_FOUND;
							end
						end
					end
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/oblivious_scan_key_value_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oblivious_scan_key_value_store
// Key-value table in insertion order with full-table scans for fetch/evict.
// ----------------------------------------------------------------------------
// One request is worked on at a time. Insert and every request rejected for
// its lengths go from the accept through the dispatch state to the finish
// state and from there into the output register. Fetch and evict with legal
// lengths read each stored entry once through the single read port of the
// entry memory, so the time to their result grows with the number of stored
// entries. The block is ready for the next request in the cycle after the
// result is loaded. While the output register holds a result that is not yet
// taken, the engine keeps its own result and stalls the input. Fetch returns
// the value of the last matching entry, or the zero-padded incoming value if
// nothing matches. Evict removes the first match and moves later entries down
// during the same pass. A finished result sits in an output register, so a
// new request is accepted while the previous result still waits to be taken.
// Configuration writes must happen while the block is idle.
// ----------------------------------------------------------------------------
module oblivious_scan_key_value_store (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [oskv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [oskv_pkg::SIZE_W-1:0]       cfg_data,
	// request channel
	input  wire logic                              req_valid,
	output      logic                              req_ready,
	input  wire oskv_pkg::req_t                    req,
	// response channel
	output      logic                              rsp_valid,
	input  wire logic                              rsp_ready,
	output      oskv_pkg::rsp_t                    rsp
);

	// configuration registers
	logic [oskv_pkg::SIZE_W-1:0] key_bytes_q;
	logic [oskv_pkg::SIZE_W-1:0] value_bytes_q;
	oskv_pkg::size_cfg_t         sizes;

	// engine <-> memory
	oskv_pkg::mem_req_t                mem_req;
	logic [oskv_pkg::ENTRY_W-1:0]      mem_rdata;

	// engine result handoff
	logic           res_valid;
	logic           res_ready;
	oskv_pkg::rsp_t res;

	// output register
	logic           rsp_valid_q;
	oskv_pkg::rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q   <= oskv_pkg::SIZE_RESET;
			value_bytes_q <= oskv_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				oskv_pkg::REG_KEY_BYTES:   key_bytes_q   <= cfg_data;
				oskv_pkg::REG_VALUE_BYTES: value_bytes_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sizes above eight bytes act as eight
	assign sizes.key_eff   = oskv_pkg::eff_size(key_bytes_q);
	assign sizes.value_eff = oskv_pkg::eff_size(value_bytes_q);

	oskv_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_valid(req_valid),
		.start_ready(req_ready),
		.start_req  (req),
		.sizes      (sizes),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// entry layout: key in the upper half, value in the lower half
	oskv_ram #(
		.DEPTH(oskv_pkg::CAPACITY),
		.WIDTH(oskv_pkg::ENTRY_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_req.raddr),
		.rdata(mem_rdata)
	);

	// output register takes a result when empty or draining
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

### rtl/core/oskv_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oskv_checker
// Port-level checks for the key-value store, bound to the top level.
// ----------------------------------------------------------------------------
module oskv_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire oskv_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire oskv_pkg::rsp_t rsp
);

	// a held response stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// a result first passes through the dispatch state
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("response appeared too early");

	// only a good fetch returns a value
	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.value_out != '0) |-> rsp.status == oskv_pkg::ST_OK)
		else $error("value returned with error status");

endmodule

bind oblivious_scan_key_value_store oskv_checker u_oskv_checker (.*);
`default_nettype wire

### test/oskv_result_check.sv
// ----------------------------------------------------------------------------
// oskv_result_check
// Watches the configuration port and both item channels of the key-value
// store, keeps its own copy of the table and the size registers, works out
// the result of every accepted request and compares it with the block.
// ----------------------------------------------------------------------------
module oskv_result_check (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [oskv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [oskv_pkg::SIZE_W-1:0]    cfg_data,
	input  wire logic                           req_valid,
	input  wire logic                           req_ready,
	input  wire oskv_pkg::req_t                 req,
	input  wire logic                           rsp_valid,
	input  wire logic                           rsp_ready,
	input  wire oskv_pkg::rsp_t                 rsp,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  n_ok,
	output int                                  n_len_err,
	output int                                  n_missing,
	output int                                  n_full
);
	timeunit 1ns;
	timeprecision 1ps;
	import oskv_pkg::*;

	logic [DATA_W-1:0] stored_keys [CAPACITY];
	logic [DATA_W-1:0] stored_vals [CAPACITY];
	int                live;
	logic [SIZE_W-1:0] key_bytes_reg;
	logic [SIZE_W-1:0] value_bytes_reg;
	rsp_t              awaited [$];
	int                fails;
	int                tally [4];

	// ones in the low n bytes, all ones from eight bytes up
	function automatic logic [DATA_W-1:0] low_bytes(input int n);
		if (n >= BYTES)
			return '1;
		return (DATA_W'(1) << (8 * n)) - DATA_W'(1);
	endfunction

	function automatic int clamp_size(input logic [SIZE_W-1:0] r);
		return (r > BYTES) ? BYTES : int'(r);
	endfunction

	function automatic rsp_t serve(input req_t r);
		rsp_t              o;
		int                ksz;
		int                vsz;
		int                hit;
		logic [DATA_W-1:0] kmask;
		logic [DATA_W-1:0] probe;
		logic [DATA_W-1:0] val;
		ksz = clamp_size(key_bytes_reg);
		vsz = clamp_size(value_bytes_reg);
		kmask = low_bytes(ksz);
		probe = r.key & low_bytes(r.key_length);
		val = r.value_in & low_bytes(r.value_length);
		o.status = ST_OK;
		o.value_out = '0;
		case (r.action)
			ACT_INSERT: begin
				if (r.key_length > ksz || r.value_length > vsz) begin
					o.status = ST_LEN_ERR;
				end else if (live >= CAPACITY) begin
					o.status = ST_FULL;
				end else begin
					stored_keys[live] = probe;
					stored_vals[live] = val;
					live++;
				end
			end
			ACT_FETCH: begin
				if (r.key_length > ksz || r.value_length > vsz) begin
					o.status = ST_LEN_ERR;
				end else begin
					// last match wins, else the padded default
					o.value_out = val;
					for (int i = 0; i < live; i++)
						if (((stored_keys[i] ^ probe) & kmask) == '0)
							o.value_out = stored_vals[i];
				end
			end
			ACT_EVICT: begin
				if (r.key_length > ksz) begin
					o.status = ST_LEN_ERR;
				end else begin
					hit = -1;
					for (int i = 0; i < live; i++)
						if (hit < 0 && ((stored_keys[i] ^ probe) & kmask) == '0)
							hit = i;
					if (hit < 0) begin
						o.status = ST_NOT_FOUND;
					end else begin
						// close the gap, order kept
						for (int i = hit; i < live - 1; i++) begin
							stored_keys[i] = stored_keys[i + 1];
							stored_vals[i] = stored_vals[i + 1];
						end
						live--;
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			live = 0;
			key_bytes_reg = SIZE_RESET;
			value_bytes_reg = SIZE_RESET;
			awaited.delete();
			fails = 0;
			for (int s = 0; s < 4; s++)
				tally[s] = 0;
			fail_count <= 0;
			pending <= 0;
			n_ok <= 0;
			n_len_err <= 0;
			n_missing <= 0;
			n_full <= 0;
		end else begin
			// a result can never belong to a request taken at the same edge
			if (rsp_valid && rsp_ready) begin
				if (awaited.size() == 0) begin
					$error("result with nothing outstanding: status %0d value_out %h",
						rsp.status, rsp.value_out);
					fails++;
				end else begin
					want = awaited.pop_front();
					tally[want.status]++;
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						fails++;
					end
					if (rsp.value_out !== want.value_out) begin
						$error("value_out: expected %h, actual %h",
							want.value_out, rsp.value_out);
						fails++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_BYTES:   key_bytes_reg = cfg_data;
					REG_VALUE_BYTES: value_bytes_reg = cfg_data;
					default: ;
				endcase
			end
			if (req_valid && req_ready)
				awaited.insert(awaited.size(), serve(req));
			fail_count <= fails;
			pending <= awaited.size();
			n_ok <= tally[ST_OK];
			n_len_err <= tally[ST_LEN_ERR];
			n_missing <= tally[ST_NOT_FOUND];
			n_full <= tally[ST_FULL];
		end
	end

endmodule

### test/tb_oblivious_scan_key_value_store.sv
// ----------------------------------------------------------------------------
// tb_oblivious_scan_key_value_store
// Drives requests into the linear-scan key-value store under several key and
// value sizes: a directed opening, then random traffic that fills the table to
// full and drains it again, with random idling on both channels and one long
// response stall. The result checker alongside predicts and compares.
// ----------------------------------------------------------------------------
module tb_oblivious_scan_key_value_store;
	timeunit 1ns;
	timeprecision 1ps;
	import oskv_pkg::*;

	localparam int RESET_CYCLES = 8;
	// the limit leaves a wide margin over the slowest legal run
	localparam int CYCLE_LIMIT  = 2_000_000;
	// covers a full-table scan
	localparam int DRAIN_CYCLES = 300;
	localparam int LONG_STALL   = 600;
	localparam int POOL_SIZE    = 16;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0]    cfg_data;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_t                 rsp;

	int fail_count;
	int pending;
	int n_ok;
	int n_len_err;
	int n_missing;
	int n_full;

	// idle chances in percent per cycle, per channel
	int tx_idle_pct;
	int rx_idle_pct;
	// one long hold-off on the response side, asked for by the stimulus
	bit stall_armed;
	bit stall_done;
	int stall_left;

	// sizes as last written, for shaping well-formed lengths
	logic [SIZE_W-1:0] key_bytes_cfg;
	logic [SIZE_W-1:0] value_bytes_cfg;
	// keys reused across the whole run so fetches and evicts find entries
	logic [DATA_W-1:0] key_pool [POOL_SIZE];
	int                items_sent;
	int                settings_used;
	int                cycle_count;

	oblivious_scan_key_value_store dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	oskv_result_check result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.n_ok       (n_ok),
		.n_len_err  (n_len_err),
		.n_missing  (n_missing),
		.n_full     (n_full)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// build one request item
	function automatic req_t make_req(input logic [1:0] act, input logic [DATA_W-1:0] k,
		input int kl, input logic [DATA_W-1:0] v, input int vl);
		req_t r;
		r.action = act;
		r.key = k;
		r.key_length = SIZE_W'(kl);
		r.value_in = v;
		r.value_length = SIZE_W'(vl);
		return r;
	endfunction

	// offer one item, idling at random first; returns at the accepting edge
	task automatic offer(input req_t item);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
		items_sent++;
	endtask

	// stop offering and wait until every result has been taken
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// both size registers, one write per edge, only with the block idle
	task automatic set_sizes(input logic [SIZE_W-1:0] kb, input logic [SIZE_W-1:0] vb);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_KEY_BYTES;
		cfg_data <= kb;
		@(posedge clk);
		cfg_index <= REG_VALUE_BYTES;
		cfg_data <= vb;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_bytes_cfg = kb;
		value_bytes_cfg = vb;
		settings_used++;
	endtask

	// one setting of the sizes followed by a stretch of random requests;
	// weights pick the action of well-formed items, noise_pct of the items are
	// fully random (any action, any lengths)
	task automatic run_phase(input logic [SIZE_W-1:0] kb, input logic [SIZE_W-1:0] vb,
		input int count, input int w_insert, input int w_fetch, input int w_evict,
		input int noise_pct);
		req_t item;
		int   ksz;
		int   vsz;
		int   pick;
		set_sizes(kb, vb);
		ksz = (key_bytes_cfg > BYTES) ? BYTES : int'(key_bytes_cfg);
		vsz = (value_bytes_cfg > BYTES) ? BYTES : int'(value_bytes_cfg);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < noise_pct) begin
				item.action = 2'($urandom);
				item.key = {$urandom, $urandom};
				item.key_length = SIZE_W'($urandom);
				item.value_in = {$urandom, $urandom};
				item.value_length = SIZE_W'($urandom);
			end else begin
				pick = $urandom_range(w_insert + w_fetch + w_evict - 1);
				if (pick < w_insert)
					item.action = ACT_INSERT;
				else if (pick < w_insert + w_fetch)
					item.action = ACT_FETCH;
				else
					item.action = ACT_EVICT;
				// mostly pool keys so lookups hit, some fresh ones that miss
				if ($urandom_range(3) == 0)
					item.key = {$urandom, $urandom};
				else
					item.key = key_pool[$urandom_range(POOL_SIZE - 1)];
				// full declared length most of the time, shorter otherwise
				if ($urandom_range(3) != 0)
					item.key_length = SIZE_W'(ksz);
				else
					item.key_length = SIZE_W'($urandom_range(ksz));
				item.value_in = {$urandom, $urandom};
				if ($urandom_range(3) != 0)
					item.value_length = SIZE_W'(vsz);
				else
					item.value_length = SIZE_W'($urandom_range(vsz));
			end
			offer(item);
		end
	endtask

	// response side: random back-pressure plus the one long hold-off
	initial begin
		rsp_ready = 1'b0;
		stall_done = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_armed && !stall_done) begin
				stall_done = 1'b1;
				stall_left = LONG_STALL;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still outstanding",
			cycle_count, pending);
		$display("tb_oblivious_scan_key_value_store NOT OK");
		$finish;
	end

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		stall_armed = 1'b0;
		tx_idle_pct = 16;
		rx_idle_pct = 60;
		key_bytes_cfg = SIZE_RESET;
		value_bytes_cfg = SIZE_RESET;
		items_sent = 0;
		settings_used = 0;
		for (int p = 0; p < POOL_SIZE; p++)
			key_pool[p] = {$urandom, $urandom};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening, sizes at their reset value of eight
		// fetch on an empty table returns the default, full and partly padded
		offer(make_req(ACT_FETCH, '1, 8, '1, 8));
		offer(make_req(ACT_FETCH, '0, 0, 64'h1122_3344_5566_7788, 3));
		// evict on an empty table finds nothing
		offer(make_req(ACT_EVICT, '1, 8, '0, 0));
		// inserts, including a duplicate key and a zero-length key and value
		offer(make_req(ACT_INSERT, '1, 8, '1, 8));
		offer(make_req(ACT_INSERT, '0, 0, 64'hDEAD_BEEF_CAFE_F00D, 0));
		offer(make_req(ACT_INSERT, '1, 8, 64'h0000_0000_0000_1234, 2));
		// the later of two equal keys wins
		offer(make_req(ACT_FETCH, '1, 8, '0, 0));
		// lengths beyond the declared sizes, for every action
		offer(make_req(ACT_INSERT, '1, 9, '1, 8));
		offer(make_req(ACT_FETCH, '1, 8, '1, 15));
		offer(make_req(ACT_EVICT, '1, 15, '0, 0));
		// evict ignores the value length and drops the first match only
		offer(make_req(ACT_EVICT, '1, 8, '1, 15));
		offer(make_req(ACT_FETCH, '1, 8, '0, 0));
		// unused action code
		offer(make_req(2'd3, {$urandom, $urandom}, 5, {$urandom, $urandom}, 6));
		// short probe is padded, so it misses the all-ones key
		offer(make_req(ACT_EVICT, '1, 4, '0, 0));
		offer(make_req(ACT_EVICT, '0, 0, '0, 0));

		// zero key size: only empty keys pass and every entry matches
		set_sizes(4'd0, 4'd3);
		offer(make_req(ACT_INSERT, '1, 0, '1, 3));
		offer(make_req(ACT_INSERT, '1, 1, '1, 3));
		offer(make_req(ACT_INSERT, '1, 0, '1, 4));
		offer(make_req(ACT_FETCH, {$urandom, $urandom}, 0, '0, 0));
		offer(make_req(ACT_EVICT, {$urandom, $urandom}, 0, '1, 15));

		// sizes above eight behave as eight
		set_sizes(4'd15, 4'd15);
		offer(make_req(ACT_INSERT, '1, 9, '1, 8));
		offer(make_req(ACT_INSERT, key_pool[0], 8, key_pool[1], 8));
		offer(make_req(ACT_FETCH, key_pool[0], 8, '0, 15));
		offer(make_req(ACT_EVICT, key_pool[0], 8, '0, 0));
		offer(make_req(2'd3, '1, 15, '1, 15));

		// random part, receiver slow
		run_phase(4'd8, 4'd8, 120, 40, 35, 25, 10);
		run_phase(4'd3, 4'd5, 120, 40, 35, 25, 10);
		run_phase(4'd1, 4'd1, 100, 40, 35, 25, 10);

		// sender slow: fill the table past capacity, then scan it while full
		tx_idle_pct = 60;
		rx_idle_pct = 16;
		run_phase(4'd8, 4'd8, 300, 100, 0, 0, 0);
		run_phase(4'd8, 4'd8, 60, 30, 50, 20, 10);

		// no idling; the long response stall lands at the start of the drain
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		stall_armed = 1'b1;
		run_phase(4'd2, 4'd8, 200, 10, 30, 60, 10);
		run_phase(4'd15, 4'd15, 120, 35, 35, 30, 20);
		run_phase(4'd0, 4'd4, 60, 40, 30, 30, 10);
		run_phase(SIZE_W'($urandom_range(15)), SIZE_W'($urandom_range(15)), 70, 40, 35, 25,
			15);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d requests under %0d size settings in %0d cycles",
			items_sent, settings_used, cycle_count);
		$display("results seen: %0d ok, %0d too long, %0d not found, %0d table full",
			n_ok, n_len_err, n_missing, n_full);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_oblivious_scan_key_value_store OK");
		end else begin
			$display("tb_oblivious_scan_key_value_store NOT OK");
		end
		$finish;
	end

endmodule
